[sv/ssc_pkg.sv]
// ssc_pkg: shared constants, types and byte compare function for the stop sequence scanner
// no dependencies; imported by every module of the scanner
`default_nettype none

package ssc_pkg;

    // sizes of the pattern bank and the text counter
    localparam int NUM_PATTERNS    = 4;
    localparam int MAX_PATTERN_LEN = 8;
    localparam int COUNT_BITS      = 20;
    localparam int HIST_DEPTH      = MAX_PATTERN_LEN - 1;

    // fixed field widths
    localparam int BYTE_BITS     = 8;
    localparam int LEN_BITS      = 4;
    localparam int CFG_DATA_BITS = 64;
    localparam int CFG_IDX_BITS  = $clog2(2 * NUM_PATTERNS);
    localparam int PAT_IDX_BITS  = (NUM_PATTERNS > 1) ? $clog2(NUM_PATTERNS) : 1;

    // result packing, matched in the lowest bit
    localparam int OUT_FIELD_BITS = 3 * COUNT_BITS + 2;
    localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;
    localparam int OFF_LSB        = 1;
    localparam int SAFE_LSB       = OFF_LSB + COUNT_BITS;
    localparam int FINAL_LSB      = SAFE_LSB + COUNT_BITS;
    localparam int SAT_BIT        = FINAL_LSB + COUNT_BITS;

    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [LEN_BITS-1:0]   len_t;
    typedef logic [BYTE_BITS-1:0]  byte_t;

    localparam count_t COUNT_MAX = {COUNT_BITS{1'b1}};

    // pattern bytes, byte i of pattern p at [p][i]
    typedef logic [NUM_PATTERNS-1:0][MAX_PATTERN_LEN-1:0][BYTE_BITS-1:0] pat_bank_t;
    typedef logic [NUM_PATTERNS-1:0][LEN_BITS-1:0]                      len_vec_t;
    // compare hits of one text byte against every pattern byte
    typedef logic [NUM_PATTERNS-1:0][MAX_PATTERN_LEN-1:0]                eq_t;

    // shift control for the history cells
    typedef struct packed {
        logic advance;
        logic clear;
    } cell_ctrl_t;

    // compare one byte against all pattern bytes
    function automatic eq_t byte_eq(input byte_t b, input pat_bank_t bank);
        eq_t res;
        for (int p = 0; p < NUM_PATTERNS; p++) begin
            for (int i = 0; i < MAX_PATTERN_LEN; i++) begin
                res[p][i] = (bank[p][i] == b);
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

[sv/ssc_cell.sv]
// ssc_cell: one history cell of the text byte chain
// depends on ssc_pkg for the byte type and the shift control struct
`default_nettype none

module ssc_cell (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  ssc_pkg::cell_ctrl_t     ctrl,
    input  ssc_pkg::byte_t          shift_in,
    output ssc_pkg::byte_t          shift_out
);
    import ssc_pkg::*;

    byte_t hold_reg;
    byte_t hold_next;

    // a new text sees an empty history
    assign shift_out = ctrl.clear ? '0 : hold_reg;

    // take the neighbor's byte on every transaction
    always_comb begin
        hold_next = hold_reg;
        if (ctrl.advance) begin
            hold_next = shift_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_reg <= '0;
        end else begin
            hold_reg <= hold_next;
        end
    end

endmodule

`default_nettype wire

[sv/ssc_pattern_regs.sv]
// ssc_pattern_regs: configuration registers for the stop patterns and their lengths
// depends on ssc_pkg for sizes and the bank types
`default_nettype none

module ssc_pattern_regs (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   cfg_wr_en,
    input  wire logic [ssc_pkg::CFG_IDX_BITS-1:0]       cfg_index,
    input  wire logic [ssc_pkg::CFG_DATA_BITS-1:0]      cfg_data,
    output ssc_pkg::pat_bank_t                          bank,
    output ssc_pkg::len_vec_t                           lens
);
    import ssc_pkg::*;

    localparam int WORD_BITS = MAX_PATTERN_LEN * BYTE_BITS;

    logic [NUM_PATTERNS-1:0][WORD_BITS-1:0] word_reg;
    logic [NUM_PATTERNS-1:0][WORD_BITS-1:0] word_next;
    len_vec_t                               len_reg;
    len_vec_t                               len_next;
    logic                                   is_word;
    logic                                   is_len;
    logic [CFG_IDX_BITS-1:0]                len_idx;

    // decode the register index
    assign is_word = ({1'b0, cfg_index} < (CFG_IDX_BITS + 1)'(NUM_PATTERNS));
    assign is_len  = !is_word && ({1'b0, cfg_index} < (CFG_IDX_BITS + 1)'(2 * NUM_PATTERNS));
    assign len_idx = cfg_index - CFG_IDX_BITS'(NUM_PATTERNS);

    always_comb begin
        word_next = word_reg;
        len_next  = len_reg;
        if (cfg_wr_en && is_word) begin
            word_next[cfg_index[PAT_IDX_BITS-1:0]] = cfg_data[WORD_BITS-1:0];
        end
        if (cfg_wr_en && is_len) begin
            len_next[len_idx[PAT_IDX_BITS-1:0]] = cfg_data[LEN_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_reg <= '0;
            len_reg  <= '0;
        end else begin
            word_reg <= word_next;
            len_reg  <= len_next;
        end
    end

    // bytes out, lengths clamped to the longest supported pattern
    always_comb begin
        for (int p = 0; p < NUM_PATTERNS; p++) begin
            for (int i = 0; i < MAX_PATTERN_LEN; i++) begin
                bank[p][i] = word_reg[p][i*BYTE_BITS +: BYTE_BITS];
            end
            lens[p] = (len_reg[p] > LEN_BITS'(MAX_PATTERN_LEN)) ?
                      LEN_BITS'(MAX_PATTERN_LEN) : len_reg[p];
        end
    end

endmodule

`default_nettype wire

[sv/stop_sequence_scanner.sv]
// stop_sequence_scanner: streaming multi-pattern stop sequence matcher, top level
// depends on ssc_pkg, ssc_cell and ssc_pattern_regs
//
//  channel | direction | handshake          | payload
//  s_      | in        | s_tvalid/s_tready  | s_tdata: text_byte; s_tuser: starts_text
//  m_      | out       | m_tvalid/m_tready  | m_tdata: matched, match_offset, release length,
//          |           |                    |          keep length, count_saturated
//  cfg_    | in        | cfg_wr_en          | cfg_index, cfg_data
//
// one text byte per cycle while s_tready is high
// the result is valid in the cycle after the transaction; the byte compares and
//   the start offset minimum are combinational ahead of the output register
// s_tready is high while the output register is empty or being drained
// synchronous active-low reset clears history, counters, patterns and output valid
`default_nettype none

module stop_sequence_scanner (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    // text input
    input  wire logic                                   s_tvalid,
    output logic                                        s_tready,
    input  wire logic [ssc_pkg::BYTE_BITS-1:0]          s_tdata,  // [7:0] text_byte
    input  wire logic                                   s_tuser,  // [0] starts_text
    // scan result
    output logic                                        m_tvalid,
    input  wire logic                                   m_tready,
    // [0] matched, [20:1] match_offset, [40:21] release length, [60:41] keep length,
    // [61] count_saturated
    output logic [ssc_pkg::OUT_DATA_BITS-1:0]           m_tdata,
    // configuration write
    input  wire logic                                   cfg_wr_en,
    input  wire logic [ssc_pkg::CFG_IDX_BITS-1:0]       cfg_index,
    input  wire logic [ssc_pkg::CFG_DATA_BITS-1:0]      cfg_data
);
    import ssc_pkg::*;

    pat_bank_t  bank;
    len_vec_t   lens;
    cell_ctrl_t cell_ctrl;
    logic       accept_in;

    byte_t      win [MAX_PATTERN_LEN];
    eq_t        win_eq [MAX_PATTERN_LEN];
    logic [NUM_PATTERNS-1:0][MAX_PATTERN_LEN-1:0] prefix_hit;

    count_t count_reg, count_next;
    logic   seen_reg, seen_next;
    count_t start_reg, start_next;
    logic   sat_reg, sat_next;

    logic                     m_tvalid_reg, m_tvalid_next;
    logic [OUT_DATA_BITS-1:0] m_tdata_reg, m_tdata_next;

    count_t safe_len;
    count_t final_len;
    count_t off_val;

    // configuration registers
    ssc_pattern_regs u_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .bank      (bank),
        .lens      (lens)
    );

    assign s_tready          = !m_tvalid_reg || m_tready;
    assign accept_in         = s_tvalid && s_tready;
    assign cell_ctrl.advance = accept_in;
    assign cell_ctrl.clear   = s_tuser;

    // history chain: win[j] is the byte j positions back
    assign win[0] = s_tdata;
    for (genvar k = 0; k < HIST_DEPTH; k++) begin : g_cell
        ssc_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (cell_ctrl),
            .shift_in  (win[k]),
            .shift_out (win[k+1])
        );
    end

    // compare every window byte against every pattern byte
    for (genvar j = 0; j < MAX_PATTERN_LEN; j++) begin : g_cmp
        assign win_eq[j] = byte_eq(win[j], bank);
    end

    // prefix of length n of pattern p equals the last n text bytes
    always_comb begin
        for (int p = 0; p < NUM_PATTERNS; p++) begin
            for (int n = 1; n <= MAX_PATTERN_LEN; n++) begin
                prefix_hit[p][n-1] = 1'b1;
                for (int i = 0; i < n; i++) begin
                    prefix_hit[p][n-1] = prefix_hit[p][n-1] && win_eq[n-1-i][p][i];
                end
            end
        end
    end

    // counter, earliest occurrence and held suffix
    always_comb begin
        count_t cnt_base;
        count_t st;
        logic   hit;
        len_t   held;
        len_t   l;

        cnt_base   = s_tuser ? '0 : count_reg;
        seen_next  = s_tuser ? 1'b0 : seen_reg;
        start_next = s_tuser ? '0 : start_reg;
        count_next = (cnt_base != COUNT_MAX) ? cnt_base + 1'b1 : cnt_base;
        sat_next   = (!s_tuser && sat_reg) || (count_next == COUNT_MAX);
        held       = '0;

        for (int p = 0; p < NUM_PATTERNS; p++) begin
            l   = lens[p];
            hit = 1'b0;
            for (int n = 1; n <= MAX_PATTERN_LEN; n++) begin
                if (l == LEN_BITS'(n) && prefix_hit[p][n-1]) begin
                    hit = 1'b1;
                end
            end
            hit = hit && (count_next >= COUNT_BITS'(l));
            st  = count_next - COUNT_BITS'(l);
            if (hit && (!seen_next || st < start_next)) begin
                start_next = st;
            end
            seen_next = seen_next || hit;

            // longest proper prefix that ends the text
            for (int n = 1; n < MAX_PATTERN_LEN; n++) begin
                if (LEN_BITS'(n) < l && COUNT_BITS'(n) <= count_next &&
                    prefix_hit[p][n-1] && LEN_BITS'(n) > held) begin
                    held = LEN_BITS'(n);
                end
            end
        end

        off_val   = seen_next ? start_next : '0;
        safe_len  = seen_next ? start_next : count_next - COUNT_BITS'(held);
        final_len = seen_next ? start_next : count_next;
    end

    // output register
    always_comb begin
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        if (accept_in) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = OUT_DATA_BITS'({sat_next, final_len, safe_len, off_val,
                                            seen_next});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            seen_reg     <= 1'b0;
            start_reg    <= '0;
            sat_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
            if (accept_in) begin
                count_reg <= count_next;
                seen_reg  <= seen_next;
                start_reg <= start_next;
                sat_reg   <= sat_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

[sv/ssc_checker.sv]
// ssc_checker: port-level assertions for the stop sequence scanner
// depends on ssc_pkg for field positions; bound to stop_sequence_scanner below
`default_nettype none

module ssc_checker (
    input wire logic                               aclk,
    input wire logic                               aresetn,
    input wire logic                               s_tvalid,
    input wire logic                               s_tready,
    input wire logic                               m_tvalid,
    input wire logic                               m_tready,
    input wire logic [ssc_pkg::OUT_DATA_BITS-1:0]  m_tdata
);
    import ssc_pkg::*;

    // no result right after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // every input transaction yields a result in the next cycle
    a_in_to_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> m_tvalid)
        else $error("input transaction without result");

    // input side is never blocked while the output is empty
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // on a match both lengths report the earliest offset, as the offset field does
    a_match_lengths: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[0]) |->
        (m_tdata[SAFE_LSB +: COUNT_BITS] == m_tdata[OFF_LSB +: COUNT_BITS]) &&
        (m_tdata[FINAL_LSB +: COUNT_BITS] == m_tdata[OFF_LSB +: COUNT_BITS]))
        else $error("match lengths disagree");

    // stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

endmodule

bind stop_sequence_scanner ssc_checker u_ssc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
